/* src/latest_frame_mailbox_with_ack_core_macros.svh */
// Assertion macros for the latest frame mailbox.
// Each takes a label, clock, active-low reset, antecedent, consequent and message.
`ifndef LATEST_FRAME_MAILBOX_WITH_ACK_CORE_MACROS_SVH
`define LATEST_FRAME_MAILBOX_WITH_ACK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define LFM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define LFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define LFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* src/lfm_pkg.sv */
`default_nettype none

package lfm_pkg;

  localparam int unsigned ID_WIDTH     = 16;
  localparam int unsigned HANDLE_WIDTH = 32;
  localparam int unsigned GEN_WIDTH    = 32;
  localparam int unsigned CNT_WIDTH    = 32;

  typedef enum logic [1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_PUBLISH = 2'd2,
    FUNC_ACK     = 2'd3
  } func_e;

  // Request payload
  typedef struct packed {
    func_e                    func;
    logic [ID_WIDTH-1:0]      requester_id;
    logic [HANDLE_WIDTH-1:0]  payload_handle;
    logic [GEN_WIDTH-1:0]     ack_generation;
  } req_t;

  // Response payload
  typedef struct packed {
    logic                     granted;
    logic                     frame_valid;
    logic [GEN_WIDTH-1:0]     frame_generation;
    logic [HANDLE_WIDTH-1:0]  frame_payload;
    logic [CNT_WIDTH-1:0]     frame_skipped;
    logic                     owner_held;
    logic [CNT_WIDTH-1:0]     total_skipped;
  } rsp_t;

  // Mailbox status seen by the top level
  typedef struct packed {
    logic owner_held;
    logic inflight_valid;
    logic pending_valid;
  } status_t;

  // Saturating counter add
  function automatic logic [CNT_WIDTH-1:0] sat_add(input logic [CNT_WIDTH-1:0] a,
                                                   input logic [CNT_WIDTH-1:0] b);
    logic [CNT_WIDTH:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_WIDTH] ? {CNT_WIDTH{1'b1}} : sum[CNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/lfm_if.sv */
`default_nettype none

// Request channel
interface lfm_req_if ();
  logic          valid;
  logic          ready;
  lfm_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Response channel
interface lfm_rsp_if ();
  logic          valid;
  logic          ready;
  lfm_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/lfm_in_reg.sv */
`default_nettype none

// Input register: holds one request until the engine consumes it.
module lfm_in_reg (
  input  wire           clk_i,
  input  wire           rst_ni,
  lfm_req_if.sink       req,
  input  wire           advance_i,
  output logic          valid_o,
  output lfm_pkg::req_t item_o
);

  logic          valid_q, valid_d;
  lfm_pkg::req_t item_q;
  logic          take;

  // Free when empty or emptied this cycle
  assign req.ready = !valid_q || advance_i;
  assign take      = req.valid && req.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= req.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* src/lfm_engine.sv */
`default_nettype none

// Mailbox state and the single-pass update for one request.
module lfm_engine (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             advance_i,
  input  lfm_pkg::req_t   item_i,
  output lfm_pkg::rsp_t   result_o,
  output lfm_pkg::status_t status_o
);

  logic [lfm_pkg::ID_WIDTH-1:0]     owner_q, owner_d;
  logic                             inf_valid_q, inf_valid_d;
  logic [lfm_pkg::GEN_WIDTH-1:0]    inf_gen_q, inf_gen_d;
  logic [lfm_pkg::HANDLE_WIDTH-1:0] inf_pay_q, inf_pay_d;
  logic                             pend_valid_q, pend_valid_d;
  logic [lfm_pkg::GEN_WIDTH-1:0]    pend_gen_q, pend_gen_d;
  logic [lfm_pkg::HANDLE_WIDTH-1:0] pend_pay_q, pend_pay_d;
  logic [lfm_pkg::CNT_WIDTH-1:0]    pend_skip_q, pend_skip_d;
  logic [lfm_pkg::CNT_WIDTH-1:0]    total_skip_q, total_skip_d;
  logic [lfm_pkg::GEN_WIDTH-1:0]    next_gen_q, next_gen_d;
  lfm_pkg::rsp_t                    res;
  logic                             id_nonzero;
  logic                             is_owner;

  assign id_nonzero = (item_i.requester_id != '0);
  assign is_owner   = (owner_q == item_i.requester_id);

  // Next state and result for the held request
  always_comb begin
    owner_d      = owner_q;
    inf_valid_d  = inf_valid_q;
    inf_gen_d    = inf_gen_q;
    inf_pay_d    = inf_pay_q;
    pend_valid_d = pend_valid_q;
    pend_gen_d   = pend_gen_q;
    pend_pay_d   = pend_pay_q;
    pend_skip_d  = pend_skip_q;
    total_skip_d = total_skip_q;
    next_gen_d   = next_gen_q;
    res          = '0;

    case (item_i.func)
      lfm_pkg::FUNC_ACQUIRE: begin
        if (id_nonzero && ((owner_q == '0) || is_owner)) begin
          owner_d     = item_i.requester_id;
          res.granted = 1'b1;
        end
      end
      lfm_pkg::FUNC_RELEASE: begin
        if (is_owner) begin
          owner_d      = '0;
          inf_valid_d  = 1'b0;
          inf_gen_d    = '0;
          inf_pay_d    = '0;
          pend_valid_d = 1'b0;
          pend_gen_d   = '0;
          pend_pay_d   = '0;
          pend_skip_d  = '0;
          total_skip_d = '0;
        end
      end
      lfm_pkg::FUNC_PUBLISH: begin
        if (owner_q != '0) begin
          next_gen_d = next_gen_q + 1'b1;
          if (inf_valid_q) begin
            // overwrite of a waiting frame counts as a skip
            if (pend_valid_q) begin
              pend_skip_d = lfm_pkg::sat_add(pend_skip_q, {{(lfm_pkg::CNT_WIDTH-1){1'b0}}, 1'b1});
            end
            pend_valid_d = 1'b1;
            pend_gen_d   = next_gen_q;
            pend_pay_d   = item_i.payload_handle;
          end else begin
            inf_valid_d          = 1'b1;
            inf_gen_d            = next_gen_q;
            inf_pay_d            = item_i.payload_handle;
            res.frame_valid      = 1'b1;
            res.frame_generation = next_gen_q;
            res.frame_payload    = item_i.payload_handle;
          end
        end
      end
      lfm_pkg::FUNC_ACK: begin
        if (is_owner && inf_valid_q && (inf_gen_q == item_i.ack_generation)) begin
          inf_valid_d = 1'b0;
          if (pend_valid_q) begin
            res.frame_valid      = 1'b1;
            res.frame_generation = pend_gen_q;
            res.frame_payload    = pend_pay_q;
            res.frame_skipped    = pend_skip_q;
            total_skip_d         = lfm_pkg::sat_add(total_skip_q, pend_skip_q);
            pend_skip_d          = '0;
            inf_valid_d          = 1'b1;
            inf_gen_d            = pend_gen_q;
            inf_pay_d            = pend_pay_q;
            pend_valid_d         = 1'b0;
            pend_gen_d           = '0;
            pend_pay_d           = '0;
          end
        end
      end
      default: begin
      end
    endcase

    res.owner_held    = (owner_d != '0);
    res.total_skipped = total_skip_d;
  end

  // State registers, updated once per consumed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q      <= '0;
      inf_valid_q  <= 1'b0;
      inf_gen_q    <= '0;
      inf_pay_q    <= '0;
      pend_valid_q <= 1'b0;
      pend_gen_q   <= '0;
      pend_pay_q   <= '0;
      pend_skip_q  <= '0;
      total_skip_q <= '0;
      next_gen_q   <= '0;
    end else if (advance_i) begin
      owner_q      <= owner_d;
      inf_valid_q  <= inf_valid_d;
      inf_gen_q    <= inf_gen_d;
      inf_pay_q    <= inf_pay_d;
      pend_valid_q <= pend_valid_d;
      pend_gen_q   <= pend_gen_d;
      pend_pay_q   <= pend_pay_d;
      pend_skip_q  <= pend_skip_d;
      total_skip_q <= total_skip_d;
      next_gen_q   <= next_gen_d;
    end
  end

  assign result_o                = res;
  assign status_o.owner_held     = (owner_q != '0);
  assign status_o.inflight_valid = inf_valid_q;
  assign status_o.pending_valid  = pend_valid_q;

endmodule

`default_nettype wire

/* src/lfm_out_reg.sv */
`default_nettype none

// Result register: holds a response until the receiver takes it.
module lfm_out_reg (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           load_i,
  input  lfm_pkg::rsp_t rsp_i,
  lfm_rsp_if.source     rsp,
  output logic          free_o
);

  logic          valid_q, valid_d;
  lfm_pkg::rsp_t rsp_q;

  // Can load when empty or being drained this cycle
  assign free_o = !valid_q || rsp.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp.valid   = valid_q;
  assign rsp.payload = rsp_q;

endmodule

`default_nettype wire

/* src/latest_frame_mailbox_with_ack_core.sv */
// Latest-frame mailbox with owner lock and stop-and-wait acknowledge.
// Requests arrive on req_i (valid/ready): acquire, release, publish a frame
// handle, or acknowledge the frame in flight by its generation. Each request
// gives exactly one response on rsp_o (valid/ready) with grant, the frame
// sent by this request if any, its skip count, owner status and total skips.
// An accepted request passes from the input register through the update
// into the result register. Throughput: one request per cycle while the
// receiver takes each response; the input register, the update logic and
// the result register form a two-entry pipe, so a request is taken while the
// previous result waits. The state update is a single pass of compares and
// at most one 32-bit increment and one saturating add between the registers.
// Reset clears the owner, both frame slots, the skip counters and the
// generation counter; no request or response is held afterwards.
// If the receiver stalls, the result register holds its response and the
// input register holds one more request; req_i.ready then drops until the
// receiver takes the waiting response. Nothing is dropped or reordered.
`default_nettype none

`include "latest_frame_mailbox_with_ack_core_macros.svh"

module latest_frame_mailbox_with_ack_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  lfm_req_if.sink    req_i,
  lfm_rsp_if.source  rsp_o
);

  logic              in_valid;
  lfm_pkg::req_t     in_item;
  lfm_pkg::rsp_t     result;
  lfm_pkg::status_t  status;
  logic              out_free;
  logic              advance;

  // Move the held request through the update when the result register frees
  assign advance = in_valid && out_free;

  lfm_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  lfm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item),
    .result_o  (result),
    .status_o  (status)
  );

  lfm_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance),
    .rsp_i  (result),
    .rsp    (rsp_o),
    .free_o (out_free)
  );

  // Checks
  `LFM_ASSERT_NOW(a_pend_needs_inflight, clk_i, rst_ni, status.pending_valid, status.inflight_valid, "pending frame without frame in flight")
  `LFM_ASSERT_NOW(a_inflight_needs_owner, clk_i, rst_ni, status.inflight_valid, status.owner_held, "frame in flight without owner")
  `LFM_ASSERT_NEXT(a_sent_is_inflight, clk_i, rst_ni, advance && result.frame_valid, rsp_o.valid && status.inflight_valid, "sent frame not tracked in flight")
  `LFM_ASSERT_NOW(a_grant_no_frame, clk_i, rst_ni, rsp_o.valid, !(rsp_o.payload.granted && rsp_o.payload.frame_valid), "grant and frame in one response")

endmodule

`default_nettype wire
